### rtl/twte_pkg.sv
package twte_pkg;

  // default sizes of the wave store and qualifier thresholds
  localparam int TABLE_DEPTH_DEF   = 1024;
  localparam int TABLE_COUNT_DEF   = 8;
  localparam int CAPTURE_COUNT_DEF = 3;
  localparam int READY_COUNT_DEF   = 5;

  // request kinds
  localparam logic [1:0] KIND_TICK        = 2'd0;
  localparam logic [1:0] KIND_PITCH_EDGE  = 2'd1;
  localparam logic [1:0] KIND_VOLUME_EDGE = 2'd2;
  localparam logic [1:0] KIND_TABLE_WRITE = 2'd3;

  // configuration register indexes
  localparam logic REG_TABLE_CHOICE = 1'b0;
  localparam logic REG_CV_MODE      = 1'b1;

  localparam int CV_MAX = 4095;

  // everything about a tick result that is known at acceptance
  typedef struct packed {
    logic        cv;
    logic [11:0] audio_cv;
    logic [15:0] step_dac;
    logic [10:0] volume_dac;
    logic [15:0] pitch_period;
    logic        pitch_ready;
    logic [15:0] volume_period;
    logic        volume_ready;
  } side_t;

endpackage

### rtl/twte_wave_mem.sv
module twte_wave_mem #(
  parameter int WORDS  = 8192,
  parameter int ADDR_W = 13
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [15:0]       wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [15:0]       rd_data
);

  logic [15:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/theremin_wavetable_tick_engine_core.sv
// pipeline: a tick's result passes through the table read, multiply and output register
// stages; other request kinds give no result.
// throughput: one request per cycle while in_stall is low; the wave store has a read
// port and a write port; stages hold under out_stall and bubbles are squeezed out.
// reset: synchronous, clears phase, counters, capture registers, configuration and
// pipeline valids; the wave store is not cleared and holds garbage until written.
module theremin_wavetable_tick_engine_core #(
  parameter int TABLE_DEPTH   = twte_pkg::TABLE_DEPTH_DEF,
  parameter int TABLE_COUNT   = twte_pkg::TABLE_COUNT_DEF,
  parameter int CAPTURE_COUNT = twte_pkg::CAPTURE_COUNT_DEF,
  parameter int READY_COUNT   = twte_pkg::READY_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [2:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic               pitch_pin,
  input  logic               volume_pin,
  input  logic [15:0]        pitch_capture,
  input  logic [15:0]        phase_step,
  input  logic [15:0]        volume_scale,
  input  logic [15:0]        volume_timer,
  input  logic [2:0]         write_table,
  input  logic [9:0]         write_offset,
  input  logic signed [15:0] write_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        audio_sample,
  output logic [15:0]        step_dac,
  output logic [10:0]        volume_dac,
  output logic [15:0]        pitch_period,
  output logic               pitch_ready,
  output logic [15:0]        volume_period,
  output logic               volume_ready
);
  import twte_pkg::*;

  localparam int WORDS  = TABLE_COUNT * TABLE_DEPTH;
  localparam int ADDR_W = $clog2(WORDS);
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int TAB_W  = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;

  // architectural state
  logic [15:0] phase_acc;
  logic [7:0]  pitch_count;
  logic [7:0]  volume_count;
  logic [15:0] last_pitch;
  logic [15:0] pitch_diff;
  logic [15:0] volume_edge_time;
  logic [15:0] last_volume;
  logic [15:0] volume_diff;
  logic [2:0]  table_choice;
  logic        cv_mode;

  // pipeline
  logic               v1;
  logic               v2;
  side_t              side1;
  side_t              side2;
  logic [15:0]        scale1;
  logic signed [32:0] prod2;
  logic [15:0]        rd_data;

  logic en_out, en2, en1, acc, tick;

  assign en_out    = !out_valid || !out_stall;
  assign en2       = !v2 || en_out;
  assign en1       = !v1 || en2;
  assign in_stall  = !en1;
  assign acc       = in_valid && !in_stall;
  assign tick      = acc && (kind == KIND_TICK);
  assign cfg_ready = 1'b1;

  // read address: selected table, entry from the top phase bits
  logic [12:0]       idx_red;
  logic [3:0]        tab_red;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    idx_red = {3'b000, phase_acc[15:6]};
    for (int k = 0; k < 4; k++) begin
      if (idx_red >= 13'(TABLE_DEPTH)) begin
        idx_red = idx_red - 13'(TABLE_DEPTH);
      end
    end
    tab_red = {1'b0, table_choice};
    for (int k = 0; k < 7; k++) begin
      if (tab_red >= 4'(TABLE_COUNT)) begin
        tab_red = tab_red - 4'(TABLE_COUNT);
      end
    end
    rd_addr = ADDR_W'(ADDR_W'(tab_red[TAB_W-1:0]) * ADDR_W'(TABLE_DEPTH))
            + ADDR_W'(idx_red[IDX_W-1:0]);
  end

  // table load
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;

  assign wr_en   = acc && (kind == KIND_TABLE_WRITE)
                && ({1'b0, write_table} < 4'(TABLE_COUNT))
                && ({3'b000, write_offset} < 13'(TABLE_DEPTH));
  assign wr_addr = ADDR_W'(ADDR_W'(write_table) * ADDR_W'(TABLE_DEPTH))
                 + ADDR_W'(write_offset);

  twte_wave_mem #(
    .WORDS  (WORDS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (write_data),
    .rd_en   (tick),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // qualifier counters and capture differences for this tick
  logic [7:0]  pitch_count_next, volume_count_next;
  logic [15:0] pitch_diff_next, volume_diff_next;
  logic        pitch_cap, volume_cap;
  side_t       side_next;

  always_comb begin
    pitch_count_next  = pitch_count + 8'(pitch_pin);
    volume_count_next = volume_count + 8'(volume_pin);
    pitch_cap         = (pitch_count_next == 8'(CAPTURE_COUNT));
    volume_cap        = (volume_count_next == 8'(CAPTURE_COUNT));
    pitch_diff_next   = pitch_cap ? (pitch_capture - last_pitch) : pitch_diff;
    volume_diff_next  = volume_cap ? (volume_edge_time - last_volume) : volume_diff;

    side_next.cv            = cv_mode;
    side_next.audio_cv      = (phase_step > 16'(CV_MAX)) ? 12'(CV_MAX) : phase_step[11:0];
    side_next.step_dac      = cv_mode ? 16'd0 : phase_step;
    side_next.volume_dac    = cv_mode ? 11'd0 : volume_scale[15:5];
    side_next.pitch_period  = pitch_diff_next;
    side_next.pitch_ready   = (pitch_count_next == 8'(READY_COUNT));
    side_next.volume_period = volume_diff_next;
    side_next.volume_ready  = (volume_count_next == 8'(READY_COUNT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc        <= '0;
      pitch_count      <= '0;
      volume_count     <= '0;
      last_pitch       <= '0;
      pitch_diff       <= '0;
      volume_edge_time <= '0;
      last_volume      <= '0;
      volume_diff      <= '0;
      table_choice     <= '0;
      cv_mode          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TABLE_CHOICE: table_choice <= cfg_data;
          REG_CV_MODE:      cv_mode      <= cfg_data[0];
          default:          ;
        endcase
      end
      if (acc) begin
        case (kind)
          KIND_TICK: begin
            if (!cv_mode) begin
              phase_acc <= phase_acc + phase_step;
            end
            pitch_count  <= pitch_count_next;
            volume_count <= volume_count_next;
            pitch_diff   <= pitch_diff_next;
            volume_diff  <= volume_diff_next;
            if (pitch_cap) begin
              last_pitch <= pitch_capture;
            end
            if (volume_cap) begin
              last_volume <= volume_edge_time;
            end
          end
          KIND_PITCH_EDGE: begin
            pitch_count <= '0;
          end
          KIND_VOLUME_EDGE: begin
            volume_edge_time <= volume_timer;
            volume_count     <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= tick;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en_out) begin
        out_valid <= v2;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en1 && tick) begin
      side1  <= side_next;
      scale1 <= volume_scale;
    end
    if (en2 && v1) begin
      side2 <= side1;
      prod2 <= $signed(rd_data) * $signed({1'b0, scale1});
    end
    if (en_out && v2) begin
      // (product >> 16) + 2048 on 12 bits flips the top bit
      audio_sample  <= side2.cv ? side2.audio_cv : {~prod2[27], prod2[26:16]};
      step_dac      <= side2.step_dac;
      volume_dac    <= side2.volume_dac;
      pitch_period  <= side2.pitch_period;
      pitch_ready   <= side2.pitch_ready;
      volume_period <= side2.volume_period;
      volume_ready  <= side2.volume_ready;
    end
  end

endmodule

### rtl/twte_checker.sv
module twte_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] audio_sample,
  input logic [15:0] pitch_period
);
  import twte_pkg::*;

  logic tick_acc;

  assign tick_acc = in_valid && !in_stall && (kind == KIND_TICK);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(audio_sample) && $stable(pitch_period))
    else $error("stalled result changed");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // a tick that meets a free output side throughout its passage must come out as a valid result
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    (tick_acc && !out_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("tick result missing");

endmodule

bind theremin_wavetable_tick_engine_core twte_checker u_twte_checker (.*);
